// ----- rtl/htd_pkg.sv -----
`default_nettype none

package htd_pkg;

	// Request command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Longest code a table entry can hold
	localparam int unsigned ENTRY_BITS_MAX = 32;

	// Character remapping on output
	localparam logic [6:0] SYM_STAR    = 7'd42;
	localparam logic [6:0] SYM_SLASH   = 7'd47;
	localparam logic [6:0] SYM_SPACE   = 7'd32;
	localparam logic [6:0] SYM_NEWLINE = 7'd10;

	typedef struct packed {
		logic        command;
		logic [6:0]  entry_symbol;
		logic [31:0] entry_code;
		logic [5:0]  entry_length;
		logic        code_bit;
	} htd_req_t;

	typedef struct packed {
		logic       symbol_valid;
		logic [6:0] decoded_symbol;
		logic       overlong;
	} htd_rsp_t;

	// One table word: masked code and its length (0 = empty)
	typedef struct packed {
		logic [31:0] code;
		logic [5:0]  length;
	} htd_entry_t;

	// Ones in the low len bits, all ones from 32 up
	function automatic logic [31:0] low_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len >= 6'(ENTRY_BITS_MAX)) begin
			m = '1;
		end else begin
			m = (32'd1 << len) - 32'd1;
		end
		return m;
	endfunction

	// Star prints as space, slash as newline
	function automatic logic [6:0] map_symbol(input logic [6:0] sym);
		logic [6:0] s;
		if (sym == SYM_STAR) begin
			s = SYM_SPACE;
		end else if (sym == SYM_SLASH) begin
			s = SYM_NEWLINE;
		end else begin
			s = sym;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/huffman_table_decoder.sv -----
`default_nettype none

// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   htd_req_t  (load entry or decode one bit)
// result    out        result_valid / result_stall  htd_rsp_t (one per request)
//
// A load request passes through the DONE state to the output register.
// A decode bit scans the whole table through the single-port table memory,
// one entry per cycle, and stops early on a match; a bit that trips or
// follows the overlong flag goes to the result without a scan.
// Reset clears the table valid bits, pending code, flag and handshakes at once.
// A finished result waits in the output register while the next request runs.

module huffman_table_decoder
	import htd_pkg::*;
#(
	parameter int SYMBOL_COUNT  = 128,
	parameter int MAX_CODE_BITS = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           item_valid,
	output logic          item_stall,
	input  wire htd_req_t item,
	output logic          result_valid,
	input  wire           result_stall,
	output htd_rsp_t      result
);

	localparam int IDX_W = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int PL_W  = $clog2(MAX_CODE_BITS + 2);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [31:0]       pend_code_q;
	logic [PL_W-1:0]   pend_len_q;
	logic              overlong_q;
	logic [IDX_W-1:0]  scan_addr_q;
	logic              issue_done_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	htd_entry_t        rd_data_s1;
	logic              rd_ent_v_s1;
	htd_rsp_t          res_q;
	htd_rsp_t          result_q;
	logic              out_valid_q;

	htd_entry_t        mem [SYMBOL_COUNT];
	logic              ent_v_q [SYMBOL_COUNT];

	logic              accept;
	logic              load_we;
	logic [IDX_W-1:0]  mem_addr;
	htd_entry_t        wr_entry;
	logic              match_s1;
	logic              last_s1;
	logic [7:0]        idx8_s1;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	// Table write: only in-range symbols, over-long lengths store an empty entry
	assign load_we  = accept && (item.command == CMD_LOAD)
		&& ({2'b00, item.entry_symbol} < 9'(SYMBOL_COUNT));
	assign mem_addr = (state_q == ST_IDLE) ? IDX_W'(item.entry_symbol) : scan_addr_q;

	always_comb begin
		if (item.entry_length > 6'(ENTRY_BITS_MAX)) begin
			wr_entry = '0;
		end else begin
			wr_entry.code   = item.entry_code & low_mask(item.entry_length);
			wr_entry.length = item.entry_length;
		end
	end

	// Compare the entry read last cycle against the pending code
	assign match_s1 = rd_vld_s1 && rd_ent_v_s1 && (rd_data_s1.length != 6'd0)
		&& (32'(rd_data_s1.length) == 32'(pend_len_q))
		&& (rd_data_s1.code == (pend_code_q & low_mask(rd_data_s1.length)));
	assign last_s1  = (rd_idx_s1 == LAST_IDX);
	assign idx8_s1  = 8'(rd_idx_s1);

	// Table memory: one port, registered read
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[mem_addr] <= wr_entry;
		end else begin
			rd_data_s1 <= mem[mem_addr];
		end
		rd_ent_v_s1 <= ent_v_q[mem_addr];
		rd_idx_s1   <= scan_addr_q;
	end

	// Entry valid bits: cleared at reset, set on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOL_COUNT; i++) begin
				ent_v_q[i] <= 1'b0;
			end
		end else if (load_we) begin
			ent_v_q[mem_addr] <= 1'b1;
		end
	end

	// Control, pending code and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_code_q  <= '0;
			pend_len_q   <= '0;
			overlong_q   <= 1'b0;
			scan_addr_q  <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			res_q        <= '0;
			result_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Drop the output once taken, unless a new result replaces it
			if (out_valid_q && !result_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						scan_addr_q  <= '0;
						issue_done_q <= 1'b0;
						if (item.command == CMD_DECODE && !overlong_q) begin
							if (pend_len_q == PL_W'(MAX_CODE_BITS)) begin
								// Code too long: raise the sticky flag
								overlong_q  <= 1'b1;
								pend_code_q <= '0;
								pend_len_q  <= '0;
								res_q       <= '{symbol_valid: 1'b0, decoded_symbol: 7'd0,
									overlong: 1'b1};
								state_q     <= ST_DONE;
							end else begin
								pend_code_q <= {pend_code_q[30:0], item.code_bit};
								pend_len_q  <= pend_len_q + 1'b1;
								state_q     <= ST_SCAN;
							end
						end else begin
							res_q   <= '{symbol_valid: 1'b0, decoded_symbol: 7'd0,
								overlong: overlong_q};
							state_q <= ST_DONE;
						end
					end
				end

				ST_SCAN: begin
					// Issue one read per cycle until the last entry
					if (!issue_done_q) begin
						scan_addr_q <= scan_addr_q + 1'b1;
						if (scan_addr_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					rd_vld_s1 <= !issue_done_q && !match_s1;

					if (match_s1) begin
						res_q       <= '{symbol_valid: 1'b1,
							decoded_symbol: map_symbol(idx8_s1[6:0]), overlong: 1'b0};
						pend_code_q <= '0;
						pend_len_q  <= '0;
						state_q     <= ST_DONE;
					end else if (rd_vld_s1 && last_s1) begin
						res_q   <= '{symbol_valid: 1'b0, decoded_symbol: 7'd0,
							overlong: overlong_q};
						state_q <= ST_DONE;
					end
				end

				ST_DONE: begin
					rd_vld_s1 <= 1'b0;
					// Hand the result over once the output register is free
					if (!out_valid_q || !result_stall) begin
						result_q    <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A symbol is never given once the code has run overlong
	a_sym_not_overlong: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.symbol_valid && result.overlong))
		else $error("symbol given with overlong flag set");

	// Overlong flag is sticky until reset
	a_overlong_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q |=> overlong_q)
		else $error("overlong flag cleared without reset");

	// Pending code never exceeds the configured maximum
	a_pend_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_len_q) <= 32'(MAX_CODE_BITS))
		else $error("pending length beyond maximum");

	// Table reads are compared only while scanning
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("table read outstanding outside scan");

endmodule

`default_nettype wire

// ----- bench/htd_symbol_monitor.sv -----
`default_nettype none

module htd_symbol_monitor
	import htd_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           item_valid,
	input  wire           item_stall,
	input  wire htd_req_t item,
	input  wire           result_valid,
	input  wire           result_stall,
	input  wire htd_rsp_t result,
	output int            fail_count,
	output int            results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 128;
	localparam int CODE_LIMIT  = 32;

	// Shadow of the code table and of the bits collected since the last symbol
	logic [31:0] tbl_code [TABLE_DEPTH];
	logic [5:0]  tbl_len  [TABLE_DEPTH];
	logic [31:0] acc_code;
	int          acc_len;
	logic        sticky_over;

	// Responses owed by the block, oldest first
	htd_rsp_t owed_q [$];

	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $time);
		fail_count++;
	endtask

	// Ones in bit positions below n, all 32 bits from n = 32 up
	function automatic logic [31:0] ones_below(input logic [5:0] n);
		logic [63:0] w;
		w = (64'd1 << n) - 64'd1;
		return w[31:0];
	endfunction

	// Star prints as space, slash as newline
	function automatic logic [6:0] printable(input logic [6:0] s);
		logic [6:0] p;
		case (s)
			SYM_STAR: begin
				p = SYM_SPACE;
			end
			SYM_SLASH: begin
				p = SYM_NEWLINE;
			end
			default: begin
				p = s;
			end
		endcase
		return p;
	endfunction

	// Apply one request to the shadow state and return the response it owes
	function automatic htd_rsp_t apply_request(input htd_req_t r);
		htd_rsp_t o;
		bit       hit;
		o = '0;
		hit = 1'b0;
		if (r.command == CMD_LOAD) begin
			if (r.entry_length > 6'(ENTRY_BITS_MAX)) begin
				tbl_code[r.entry_symbol] = '0;
				tbl_len[r.entry_symbol]  = '0;
			end else begin
				tbl_code[r.entry_symbol] = r.entry_code & ones_below(r.entry_length);
				tbl_len[r.entry_symbol]  = r.entry_length;
			end
		end else if (!sticky_over) begin
			if (acc_len + 1 > CODE_LIMIT) begin
				sticky_over = 1'b1;
				acc_code = '0;
				acc_len = 0;
			end else begin
				acc_code = {acc_code[30:0], r.code_bit};
				acc_len++;
				// lowest index wins when several entries match
				for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
					if (tbl_len[i] != 6'd0 && int'(tbl_len[i]) == acc_len &&
						tbl_code[i] == (acc_code & ones_below(tbl_len[i]))) begin
						hit = 1'b1;
						o.symbol_valid = 1'b1;
						o.decoded_symbol = printable(7'(i));
						acc_code = '0;
						acc_len = 0;
					end
				end
			end
		end
		o.overlong = sticky_over;
		return o;
	endfunction

	// Retire responses first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin : watch_channels
		htd_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tbl_code[i] = '0;
				tbl_len[i]  = '0;
			end
			acc_code = '0;
			acc_len = 0;
			sticky_over = 1'b0;
			owed_q.delete();
			fail_count = 0;
			results_owed <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (owed_q.size() == 0) begin
					report_mismatch("response with nothing owed", 32'd0, 32'd1);
				end else begin
					want = owed_q.pop_front();
					if (result.symbol_valid !== want.symbol_valid) begin
						report_mismatch("symbol_valid", 32'(want.symbol_valid),
							32'(result.symbol_valid));
					end
					if (result.decoded_symbol !== want.decoded_symbol) begin
						report_mismatch("decoded_symbol", 32'(want.decoded_symbol),
							32'(result.decoded_symbol));
					end
					if (result.overlong !== want.overlong) begin
						report_mismatch("overlong", 32'(want.overlong), 32'(result.overlong));
					end
				end
			end
			if (item_valid && !item_stall) begin
				owed_q.push_back(apply_request(item));
			end
			results_owed <= owed_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench
	import htd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int TARGET_ITEMS = 1950;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	htd_req_t item;
	logic     result_valid;
	logic     result_stall = 1'b0;
	htd_rsp_t result;
	int       fail_count;
	int       results_owed;

	// Idle-free stretches when set
	bit calm = 1'b0;
	int sent_items = 0;
	int cycles = 0;
	int stall_left = 0;

	// Current code tree as the stimulus sees it, and where the stream stands in it
	logic [31:0] leaf_code [$];
	int          leaf_len  [$];
	logic [6:0]  leaf_sym  [$];
	bit          in_use    [128];
	logic [31:0] walk_code = '0;
	int          walk_len = 0;

	huffman_table_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	htd_symbol_monitor symbol_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly short idle spells, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Stall the response channel at random
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	function automatic htd_req_t noise_fields();
		htd_req_t r;
		r.command      = 1'($urandom);
		r.entry_symbol = 7'($urandom);
		r.entry_code   = $urandom;
		r.entry_length = 6'($urandom);
		r.code_bit     = 1'($urandom);
		return r;
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic push_request(input htd_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= r;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent_items++;
	endtask

	// Send one code bit and follow it down the tree
	task automatic send_bit(input logic b);
		htd_req_t r;
		r = noise_fields();
		r.command = CMD_DECODE;
		r.code_bit = b;
		push_request(r);
		walk_code = {walk_code[30:0], b};
		walk_len++;
		for (int k = 0; k < leaf_len.size(); k++) begin
			if (leaf_len[k] == walk_len && leaf_code[k] == walk_code) begin
				walk_code = '0;
				walk_len = 0;
				break;
			end
		end
	endtask

	task automatic send_load(input logic [6:0] sym, input logic [31:0] code,
		input logic [5:0] len);
		htd_req_t r;
		r = noise_fields();
		r.command = CMD_LOAD;
		r.entry_symbol = sym;
		r.entry_code = code;
		r.entry_length = len;
		push_request(r);
		in_use[sym] = (len != 6'd0 && len <= 6'd32);
	endtask

	// Load an entry with random junk above its code bits
	task automatic load_entry(input logic [6:0] sym, input logic [31:0] val, input int len);
		logic [63:0] junk;
		junk = {32'($urandom), 32'($urandom)} << len;
		send_load(sym, val | junk[31:0], 6'(len));
	endtask

	// Empty an entry, either by length zero or by a length past the limit
	task automatic clear_entry(input logic [6:0] sym);
		if ($urandom_range(0, 1) == 1) begin
			send_load(sym, $urandom, 6'd0);
		end else begin
			send_load(sym, $urandom, 6'($urandom_range(33, 63)));
		end
	endtask

	task automatic send_codeword(input int k);
		for (int b = leaf_len[k] - 1; b >= 0; b--) begin
			send_bit(leaf_code[k][b]);
		end
	endtask

	// Finish the open code, then hold off until every response is in
	task automatic settle();
		while (walk_len != 0) send_bit(1'b0);
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	// Grow a complete prefix code by splitting leaves, then load it
	task automatic build_table(input int k, input bit chain);
		bit         taken [128];
		int         idx;
		logic       c;
		logic [6:0] s;
		leaf_code.delete();
		leaf_len.delete();
		leaf_sym.delete();
		leaf_code.push_back(32'd0);
		leaf_len.push_back(1);
		leaf_code.push_back(32'd1);
		leaf_len.push_back(1);
		while (leaf_len.size() < k) begin
			idx = chain ? leaf_len.size() - 1 : $urandom_range(0, leaf_len.size() - 1);
			if (leaf_len[idx] >= 32) begin
				if (chain) begin
					break;
				end
				continue;
			end
			c = 1'($urandom);
			leaf_code.push_back({leaf_code[idx][30:0], c});
			leaf_len.push_back(leaf_len[idx] + 1);
			leaf_code[idx] = {leaf_code[idx][30:0], ~c};
			leaf_len[idx]++;
		end
		for (int j = 0; j < leaf_len.size(); j++) begin
			do begin
				s = 7'($urandom);
			end while (taken[s]);
			taken[s] = 1'b1;
			leaf_sym.push_back(s);
		end
		// drop entries of the old tree that the new one does not reuse
		for (int i = 0; i < 128; i++) begin
			if (in_use[i] && !taken[i]) begin
				clear_entry(7'(i));
			end
		end
		for (int j = 0; j < leaf_len.size(); j++) begin
			load_entry(leaf_sym[j], leaf_code[j], leaf_len[j]);
		end
		// sometimes give one code to a second symbol
		if ($urandom_range(0, 2) == 0) begin
			idx = $urandom_range(0, leaf_len.size() - 1);
			do begin
				s = 7'($urandom);
			end while (taken[s]);
			load_entry(s, leaf_code[idx], leaf_len[idx]);
		end
	endtask

	initial begin : stimulus
		bit         chain;
		int         quota;
		int         start;
		int         pick;
		logic [6:0] s;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bit into an empty table: no symbol
		send_bit(1'b1);

		// Small tree with star and slash, both ends of the symbol range
		leaf_code = '{32'd0, 32'd2, 32'd6, 32'd7};
		leaf_len  = '{1, 2, 3, 3};
		leaf_sym  = '{SYM_STAR, SYM_SLASH, 7'd0, 7'd127};
		for (int j = 0; j < 4; j++) begin
			load_entry(leaf_sym[j], leaf_code[j], leaf_len[j]);
		end
		// duplicates above and below the owner, an unreachable full-width code
		load_entry(7'd100, 32'd0, 1);
		load_entry(7'd3, 32'd7, 3);
		load_entry(7'd1, 32'hFFFF_FFFF, 32);
		// lengths that leave the entry empty
		send_load(7'd99, 32'hFFFF_FFFF, 6'd40);
		send_load(7'd98, 32'hFFFF_FFFF, 6'd0);
		send_load(7'd97, 32'hFFFF_FFFF, 6'd63);
		send_load(7'd96, 32'hFFFF_FFFF, 6'd33);
		send_bit(1'b0);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b0);
		settle();

		// Random trees, mostly whole codewords with some stray bits and loads
		while (sent_items < TARGET_ITEMS - 150) begin
			calm = ($urandom_range(0, 3) == 0);
			chain = ($urandom_range(0, 5) == 0);
			build_table(chain ? 33 : $urandom_range(2, 24), chain);
			quota = $urandom_range(40, 160);
			start = sent_items;
			while (sent_items - start < quota) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					send_codeword($urandom_range(0, leaf_len.size() - 1));
				end else if (pick < 92) begin
					send_bit(1'($urandom));
				end else begin
					do begin
						s = 7'($urandom);
					end while (in_use[s]);
					clear_entry(s);
				end
			end
			settle();
		end

		// Empty the table and push the pending code past its limit
		calm = 1'b0;
		for (int i = 0; i < 128; i++) begin
			if (in_use[i]) begin
				clear_entry(7'(i));
			end
		end
		leaf_code.delete();
		leaf_len.delete();
		leaf_sym.delete();
		repeat (33) send_bit(1'($urandom));
		// sticky flag: a matching code no longer decodes
		load_entry(SYM_STAR, 32'd0, 1);
		repeat (4) send_bit(1'b0);
		send_load(7'd10, $urandom, 6'd5);
		send_bit(1'b1);
		item_valid <= 1'b0;

		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
